@@ rtl/sbph_pkg.sv @@
package sbph_pkg;

  localparam int unsigned BANDS_DEF = 256;
  localparam int unsigned HEIGHT_FRAC_BITS_DEF = 8;

  localparam int unsigned LOG_FRAC_BITS = 12;
  localparam int unsigned SPEED_W = 24;

  localparam logic [SPEED_W-1:0] SPEED_RESET = 24'd655;
  localparam logic [SPEED_W-1:0] SPEED_MAX = 24'hFF_FFFF;
  localparam logic [14:0] LOG10_2_Q16 = 15'd19729;

  // ceil(2^30 / 125) and ceil(2^37 / 125), exact for the operand ranges used
  localparam logic [23:0] RECIP_125_Q30 = 24'd8589935;
  localparam logic [30:0] RECIP_125_Q37 = 31'd1099511628;

  localparam logic [15:0] FALL_RATE_RST = 16'd1271;
  localparam logic [11:0] PEAK_ACCEL_RST = 12'd1103;
  localparam logic [15:0] HEIGHT_SCALE_RST = 16'd9658;
  localparam logic [11:0] HEIGHT_LIMIT_RST = 12'd99;

  typedef enum logic [1:0] {
    REG_FALL_RATE    = 2'd0,
    REG_PEAK_ACCEL   = 2'd1,
    REG_HEIGHT_SCALE = 2'd2,
    REG_HEIGHT_LIMIT = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    SPD_KEEP,
    SPD_RESET,
    SPD_MULT
  } spd_mode_t;

endpackage

@@ rtl/sbph_ram.sv @@
module sbph_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/spectrum_bar_peak_hold_top.sv @@
// Throughput: one request per cycle while the output is not stalled. A request whose
// band matches one of the four requests in the read-modify-write stages after the
// band memory read waits until that write lands; the peak speed update spans those
// stages. Reset: registers return to defaults, then the band memory is cleared, one
// entry a cycle, with s_axis_tready low.
module spectrum_bar_peak_hold_top
  import sbph_pkg::*;
#(
  parameter int unsigned BANDS = BANDS_DEF,
  parameter int unsigned HEIGHT_FRAC_BITS = HEIGHT_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // band[7:0], magnitude[23:8]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // band_out[7:0], bar_pixels[19:8], peak_pixels[31:20]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned H = HEIGHT_FRAC_BITS;
  localparam int unsigned HW = 12 + H;
  localparam int unsigned EW = 2 * HW + SPEED_W;
  localparam int unsigned AW = $clog2(BANDS);
  localparam int unsigned NL = LOG_FRAC_BITS;
  localparam int unsigned HSHIFT = 36 - H;
  localparam int unsigned FALL_W = H + 7;
  localparam int unsigned FY_W = H + 17;
  localparam int unsigned FP_W = H + 45;

  // config registers
  logic [15:0] fall_rate_milli;
  logic [11:0] peak_accel_milli;
  logic [15:0] height_scale;
  logic [11:0] height_limit;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fall_rate_milli  <= FALL_RATE_RST;
      peak_accel_milli <= PEAK_ACCEL_RST;
      height_scale     <= HEIGHT_SCALE_RST;
      height_limit     <= HEIGHT_LIMIT_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx_t'(paddr[3:2]))
        REG_FALL_RATE:    fall_rate_milli  <= pwdata[15:0];
        REG_PEAK_ACCEL:   peak_accel_milli <= pwdata[11:0];
        REG_HEIGHT_SCALE: height_scale     <= pwdata[15:0];
        REG_HEIGHT_LIMIT: height_limit     <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[3:2]))
      REG_FALL_RATE:    prdata = 32'(fall_rate_milli);
      REG_PEAK_ACCEL:   prdata = 32'(peak_accel_milli);
      REG_HEIGHT_SCALE: prdata = 32'(height_scale);
      REG_HEIGHT_LIMIT: prdata = 32'(height_limit);
      default:          prdata = '0;
    endcase
  end

  // bar fall step = round(fall_rate_milli * 2^H / 1000), follows the register
  logic [FY_W-1:0]   fall_y;
  logic [FY_W-4:0]   fall_w;
  logic [FP_W-1:0]   fall_prod;
  logic [FALL_W-1:0] fall_step;

  assign fall_y = FY_W'({fall_rate_milli, {H{1'b0}}}) + FY_W'(500);
  assign fall_step = fall_prod[37 +: FALL_W];

  always_ff @(posedge clk) begin
    fall_w    <= fall_y[FY_W-1:3];
    fall_prod <= FP_W'(fall_w) * FP_W'(RECIP_125_Q37);
  end

  // memory clearing pass
  logic          clearing;
  logic [AW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == AW'(BANDS - 1)) begin
        clearing <= 1'b0;
      end else begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  // pipeline control
  logic en;
  logic out_load;
  logic hazard;
  logic front_adv;

  logic                  v_q    [1:4];
  logic [7:0]            band_q [1:4];
  logic                  inr_q  [1:4];

  logic                  rd_v;
  logic [7:0]            rd_band;
  logic                  rd_inr;
  logic [HW-1:0]         rd_h;

  assign out_load  = !m_axis_tvalid || m_axis_tready;
  assign en        = out_load || !v_q[4];
  assign front_adv = en && !hazard;
  assign s_axis_tready = front_adv && !clearing;

  always_comb begin
    hazard = 1'b0;
    for (int i = 1; i <= 4; i++) begin
      if (v_q[i] && inr_q[i] && band_q[i] == rd_band) begin
        hazard = 1'b1;
      end
    end
    hazard = hazard && rd_v && rd_inr;
  end

  // log2 front end: normalize, then one squaring per stage
  logic [7:0]  in_band;
  logic [15:0] in_mag;
  logic [3:0]  norm_e;
  logic [15:0] norm_x;

  assign in_band = s_axis_tdata[7:0];
  assign in_mag  = s_axis_tdata[23:8];

  always_comb begin
    norm_e = '0;
    for (int i = 1; i < 16; i++) begin
      if (in_mag[i]) begin
        norm_e = 4'(i);
      end
    end
  end

  assign norm_x = in_mag << (4'd15 - norm_e);

  logic          lv  [0:NL];
  logic [15:0]   lx  [0:NL];
  logic [NL-1:0] lf  [0:NL];
  logic [3:0]    le  [0:NL];
  logic [7:0]    lb  [0:NL];
  logic          lin [0:NL];

  logic [31:0]   sq_full [1:NL];
  logic [15:0]   sq_x    [1:NL];
  logic [NL-1:0] sq_f    [1:NL];

  always_comb begin
    for (int i = 1; i <= NL; i++) begin
      sq_full[i] = 32'(lx[i-1]) * 32'(lx[i-1]);
      sq_f[i] = lf[i-1];
      if (sq_full[i][31]) begin
        sq_x[i] = sq_full[i][31:16];
        sq_f[i][NL-i] = 1'b1;
      end else begin
        sq_x[i] = sq_full[i][30:15];
      end
    end
  end

  logic          h1_v;
  logic [7:0]    h1_band;
  logic          h1_inr;
  logic [31:0]   h1_p;
  logic          h2_v;
  logic [7:0]    h2_band;
  logic          h2_inr;
  logic [46:0]   h2_p;
  logic [HW-1:0] h_lim;
  logic [HW-1:0] h_raw;
  logic [HW-1:0] h_clip;

  assign h_lim  = {height_limit, {H{1'b0}}};
  assign h_raw  = HW'(h2_p[46:HSHIFT]);
  assign h_clip = (h_raw > h_lim) ? h_lim : h_raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= NL; i++) begin
        lv[i] <= 1'b0;
      end
      h1_v <= 1'b0;
      h2_v <= 1'b0;
      rd_v <= 1'b0;
    end else if (front_adv) begin
      lv[0]  <= s_axis_tvalid && !clearing;
      lx[0]  <= norm_x;
      lf[0]  <= '0;
      le[0]  <= norm_e;
      lb[0]  <= in_band;
      lin[0] <= 32'(in_band) < BANDS;
      for (int i = 1; i <= NL; i++) begin
        lv[i]  <= lv[i-1];
        lx[i]  <= sq_x[i];
        lf[i]  <= sq_f[i];
        le[i]  <= le[i-1];
        lb[i]  <= lb[i-1];
        lin[i] <= lin[i-1];
      end
      h1_v    <= lv[NL];
      h1_band <= lb[NL];
      h1_inr  <= lin[NL];
      h1_p    <= 32'({le[NL], lf[NL]}) * 32'(height_scale);
      h2_v    <= h1_v;
      h2_band <= h1_band;
      h2_inr  <= h1_inr;
      h2_p    <= 47'(h1_p) * 47'(LOG10_2_Q16);
      rd_v    <= h2_v;
      rd_band <= h2_band;
      rd_inr  <= h2_inr;
      rd_h    <= h_clip;
    end
  end

  // band memory: {speed, peak, bar}
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [EW-1:0] mem_wdata;
  logic [EW-1:0] mem_rdata;

  sbph_ram #(
    .WIDTH(EW),
    .DEPTH(BANDS)
  ) u_band_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (en),
    .raddr(AW'(rd_band)),
    .rdata(mem_rdata)
  );

  // read-modify-write stage 1
  logic [HW-1:0]      e1_h;
  logic [HW-1:0]      m_bar;
  logic [HW-1:0]      m_peak;
  logic [SPEED_W-1:0] m_spd;
  logic               rise;
  logic [HW-1:0]      bar_fell;
  logic [HW-1:0]      bar_new;
  logic [SPEED_W-1:0] dec;
  logic [HW-1:0]      peak_dec;
  logic [HW-1:0]      peak_new;
  spd_mode_t          mode_new;

  assign m_bar  = mem_rdata[HW-1:0];
  assign m_peak = mem_rdata[2*HW-1:HW];
  assign m_spd  = mem_rdata[EW-1:2*HW];

  always_comb begin
    rise     = e1_h > m_bar;
    bar_fell = (m_bar > HW'(fall_step)) ? m_bar - HW'(fall_step) : '0;
    bar_new  = rise ? e1_h : bar_fell;
    dec      = m_spd >> (16 - H);
    peak_dec = (32'(m_peak) > 32'(dec)) ? HW'(32'(m_peak) - 32'(dec)) : '0;
    if (rise && e1_h > m_peak) begin
      peak_new = e1_h;
      mode_new = SPD_RESET;
    end else if (m_peak == '0) begin
      peak_new = m_peak;
      mode_new = SPD_KEEP;
    end else begin
      peak_new = (peak_dec < bar_new) ? bar_new : peak_dec;
      mode_new = SPD_MULT;
    end
  end

  logic [HW-1:0]      bar_q  [2:4];
  logic [HW-1:0]      peak_q [2:4];
  logic [SPEED_W-1:0] spd_q  [2:4];
  spd_mode_t          mode_q [2:4];
  logic [35:0]        p_q;
  logic [25:0]        u_q;
  logic [26:0]        hq_q;
  logic [26:0]        hq4_q;
  logic [46:0]        m_q;

  // floor(p / 1000) = 262 * ph + floor((144 * ph + pl) / 1000), p = ph * 2^18 + pl
  logic [17:0] ph;
  logic [17:0] pl;
  logic [26:0] spd_q27;
  logic [SPEED_W-1:0] spd_mult;
  logic [SPEED_W-1:0] spd_new;

  assign ph = p_q[35:18];
  assign pl = p_q[17:0];
  assign spd_q27 = hq4_q + 27'(m_q[46:30]);
  assign spd_mult = (spd_q27 > 27'(SPEED_MAX)) ? SPEED_MAX : spd_q27[SPEED_W-1:0];

  always_comb begin
    case (mode_q[4])
      SPD_RESET: spd_new = SPEED_RESET;
      SPD_MULT:  spd_new = spd_mult;
      default:   spd_new = spd_q[4];
    endcase
  end

  always_comb begin
    if (clearing) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = {SPEED_RESET, {(2 * HW){1'b0}}};
    end else begin
      mem_we    = en && v_q[4] && inr_q[4];
      mem_waddr = AW'(band_q[4]);
      mem_wdata = {spd_new, peak_q[4], bar_q[4]};
    end
  end

  logic [31:0] out_data;
  assign m_axis_tdata = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 1; i <= 4; i++) begin
        v_q[i] <= 1'b0;
      end
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      v_q[1]    <= rd_v && !hazard;
      band_q[1] <= rd_band;
      inr_q[1]  <= rd_inr;
      e1_h      <= rd_h;
      for (int i = 2; i <= 4; i++) begin
        v_q[i]    <= v_q[i-1];
        band_q[i] <= band_q[i-1];
        inr_q[i]  <= inr_q[i-1];
      end
      bar_q[2]  <= bar_new;
      peak_q[2] <= peak_new;
      spd_q[2]  <= m_spd;
      mode_q[2] <= mode_new;
      p_q       <= 36'(m_spd) * 36'(peak_accel_milli);
      for (int i = 3; i <= 4; i++) begin
        bar_q[i]  <= bar_q[i-1];
        peak_q[i] <= peak_q[i-1];
        spd_q[i]  <= spd_q[i-1];
        mode_q[i] <= mode_q[i-1];
      end
      u_q   <= 26'({ph, 7'b0}) + 26'({ph, 4'b0}) + 26'(pl);
      hq_q  <= 27'({ph, 8'b0}) + 27'({ph, 2'b0}) + 27'({ph, 1'b0});
      m_q   <= 47'(u_q[25:3]) * 47'(RECIP_125_Q30);
      hq4_q <= hq_q;
      if (out_load) begin
        m_axis_tvalid  <= v_q[4];
        out_data[7:0]  <= band_q[4];
        out_data[19:8] <= inr_q[4] ? bar_q[4][H +: 12] : 12'd0;
        out_data[31:20] <= inr_q[4] ? peak_q[4][H +: 12] : 12'd0;
      end
    end
  end

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps

module testbench
  import sbph_pkg::*;
();

  localparam int HFB = 8;
  localparam int NBANDS = 256;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_STALL = 400;
  localparam int ITEMS_PER_PHASE = 180;

  typedef struct {
    logic [7:0]  band;
    logic [11:0] bar;
    logic [11:0] peak;
  } meter_result_t;

  class level_meter_model;
    logic [19:0]   bar_lvl [NBANDS];
    logic [19:0]   peak_lvl [NBANDS];
    logic [23:0]   fall_speed [NBANDS];
    logic [15:0]   fall_rate;
    logic [11:0]   peak_accel;
    logic [15:0]   scale;
    logic [11:0]   max_h;
    meter_result_t expected_meters[$];
    int            errors;
    int            checked;

    function new();
      for (int i = 0; i < NBANDS; i++) begin
        bar_lvl[i] = '0;
        peak_lvl[i] = '0;
        fall_speed[i] = 24'd655;
      end
      fall_rate = 16'd1271;
      peak_accel = 12'd1103;
      scale = 16'd9658;
      max_h = 12'd99;
      errors = 0;
      checked = 0;
    endfunction

    function void write_reg(reg_idx_t idx, logic [31:0] value);
      case (idx)
        REG_FALL_RATE:    fall_rate = value[15:0];
        REG_PEAK_ACCEL:   peak_accel = value[11:0];
        REG_HEIGHT_SCALE: scale = value[15:0];
        REG_HEIGHT_LIMIT: max_h = value[11:0];
        default: ;
      endcase
    endfunction

    // Q4.12 log2 by repeated squaring of the Q1.15 mantissa
    function logic [15:0] log2_fix(logic [15:0] m);
      int unsigned e;
      logic [63:0] x;
      logic [11:0] frac;
      int i;
      e = 0;
      frac = '0;
      while (e < 15 && (m >> (e + 1)) != 0) e++;
      x = 64'(m) << (15 - e);
      for (i = 11; i >= 0; i--) begin
        x = (x * x) >> 15;
        if (x >= 64'd65536) begin
          x = x >> 1;
          frac[i] = 1'b1;
        end
      end
      return {e[3:0], frac};
    endfunction

    function logic [19:0] height_of(logic [15:0] m);
      logic [63:0] prod;
      logic [63:0] limit;
      if (m <= 16'd1) return '0;
      limit = 64'(max_h) << HFB;
      prod = 64'(log2_fix(m)) * 64'd19729 * 64'(scale);
      prod = prod >> (36 - HFB);
      if (prod > limit) prod = limit;
      return prod[19:0];
    endfunction

    function void peak_drop(int b);
      logic [19:0] p;
      logic [23:0] dec;
      logic [63:0] s;
      p = peak_lvl[b];
      if (p == 0) return;
      dec = fall_speed[b] >> (16 - HFB);
      p = (24'(p) > dec) ? p - dec[19:0] : '0;
      s = 64'(fall_speed[b]) * 64'(peak_accel) / 64'd1000;
      if (s > 64'hFF_FFFF) s = 64'hFF_FFFF;
      fall_speed[b] = s[23:0];
      if (p < bar_lvl[b]) p = bar_lvl[b];
      peak_lvl[b] = p;
    endfunction

    function void note_request(logic [7:0] band, logic [15:0] mag);
      logic [19:0] h;
      logic [63:0] fall;
      meter_result_t r;
      int b;
      b = band;
      h = height_of(mag);
      if (h > bar_lvl[b]) begin
        bar_lvl[b] = h;
        if (h > peak_lvl[b]) begin
          peak_lvl[b] = h;
          fall_speed[b] = 24'd655;
        end else begin
          peak_drop(b);
        end
      end else begin
        if (bar_lvl[b] > 0) begin
          fall = ((64'(fall_rate) << HFB) + 64'd500) / 64'd1000;
          bar_lvl[b] = (64'(bar_lvl[b]) > fall) ? bar_lvl[b] - fall[19:0] : '0;
        end
        peak_drop(b);
      end
      r.band = band;
      r.bar = 12'(bar_lvl[b] >> HFB);
      r.peak = 12'(peak_lvl[b] >> HFB);
      expected_meters.push_back(r);
    endfunction

    function void check_result(logic [31:0] data);
      meter_result_t exp_r;
      checked++;
      if (expected_meters.size() == 0) begin
        $display("%0t: unexpected result band %0d bar %0d peak %0d", $time,
                 data[7:0], data[19:8], data[31:20]);
        errors++;
        return;
      end
      exp_r = expected_meters.pop_front();
      if (data[7:0] !== exp_r.band) begin
        $display("%0t: band_out expected %0d actual %0d", $time, exp_r.band, data[7:0]);
        errors++;
      end
      if (data[19:8] !== exp_r.bar) begin
        $display("%0t: bar_pixels (band %0d) expected %0d actual %0d", $time,
                 exp_r.band, exp_r.bar, data[19:8]);
        errors++;
      end
      if (data[31:20] !== exp_r.peak) begin
        $display("%0t: peak_pixels (band %0d) expected %0d actual %0d", $time,
                 exp_r.band, exp_r.peak, data[31:20]);
        errors++;
      end
    endfunction

    function int pending();
      return expected_meters.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;   // band[7:0], magnitude[23:8]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // band_out[7:0], bar_pixels[19:8], peak_pixels[31:20]
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  level_meter_model meter = new();

  int send_idle_pct = 6;
  int recv_idle_pct = 77;
  int stall_req_cnt = 0;
  int stall_seen = 0;
  int stall_left = 0;
  int idle_cycles = 0;
  int requests_sent = 0;
  int settings_used = 1;
  logic [7:0] hot_bands [6];

  spectrum_bar_peak_hold_top u_top (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) meter.note_request(s_axis_tdata[7:0], s_axis_tdata[23:8]);
      if (m_axis_tvalid && m_axis_tready) meter.check_result(m_axis_tdata);
      if (psel && penable && pwrite && pready) meter.write_reg(reg_idx_t'(paddr[3:2]), pwdata);
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stall_seen != stall_req_cnt) begin
      stall_seen <= stall_req_cnt;
      stall_left <= LONG_STALL;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic send_request(logic [7:0] band, logic [15:0] mag);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {mag, band};
    do @(posedge clk); while (!s_axis_tready);
    requests_sent++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (meter.pending() != 0) @(posedge clk);
    repeat (25) @(posedge clk);
  endtask

  task automatic apb_write(reg_idx_t idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // upper bits of each write carry junk that the register must drop
  task automatic set_meter_config(int unsigned fall, int unsigned accel,
                                  int unsigned scl, int unsigned maxh);
    apb_write(REG_FALL_RATE, fall | ($urandom << 16));
    apb_write(REG_PEAK_ACCEL, accel | ($urandom << 12));
    apb_write(REG_HEIGHT_SCALE, scl | ($urandom << 16));
    apb_write(REG_HEIGHT_LIMIT, maxh | ($urandom << 12));
    settings_used++;
  endtask

  task automatic send_random();
    logic [7:0]  band;
    logic [15:0] mag;
    int pick;
    band = ($urandom_range(99) < 85) ? hot_bands[$urandom_range(5)] : 8'($urandom);
    pick = $urandom_range(99);
    if (pick < 35) mag = '0;
    else if (pick < 50) mag = 16'($urandom);
    else if (pick < 80) mag = 16'($urandom) >> $urandom_range(15);
    else if (pick < 90) mag = 16'($urandom_range(2));
    else mag = 16'hFFFF;
    send_request(band, mag);
  endtask

  initial begin
    int ph;
    int i;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, rise below peak, long falls
    send_request(8'd0, 16'd0);
    send_request(8'd0, 16'd1);
    send_request(8'd1, 16'd2);
    send_request(8'd255, 16'hFFFF);
    repeat (3) send_request(8'd255, 16'd0);
    send_request(8'd255, 16'd300);
    send_request(8'd255, 16'd0);
    send_request(8'd255, 16'hFFFF);
    send_request(8'hAA, 16'hAAAA);
    send_request(8'h55, 16'h5555);
    send_request(8'd2, 16'd1000);
    repeat (8) send_request(8'd2, 16'd0);
    send_request(8'd2, 16'd40);

    for (ph = 1; ph <= 6; ph++) begin
      drain();
      case (ph)
        1: set_meter_config(0, 4000, 65535, 4095);
        2: set_meter_config(65535, 1000, 0, 1);
        3: set_meter_config(300, 4095, 20000, 0);
        4: set_meter_config(50, 0, 30000, 200);
        5: set_meter_config(800, 500, 12000, 4095);
        default: set_meter_config($urandom_range(65535), $urandom_range(1000, 4000),
                                  $urandom_range(65535), $urandom_range(1, 4095));
      endcase
      if (ph == 3) begin
        send_idle_pct <= 77;
        recv_idle_pct <= 6;
      end else if (ph == 5) begin
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
        stall_req_cnt <= stall_req_cnt + 1;
      end
      for (i = 0; i < 6; i++) hot_bands[i] = 8'($urandom);
      hot_bands[0] = (ph[0]) ? 8'd0 : 8'd255;
      for (i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (ph == 4 && i == ITEMS_PER_PHASE / 2) drain();
        send_random();
      end
    end

    drain();
    repeat (40) @(posedge clk);
    $display("Sent %0d requests over %0d register settings, checked %0d results,",
             requests_sent, settings_used, meter.checked);
    $display("with input and output idling, a long output stall and a full drain pause.");
    if (meter.errors == 0 && meter.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ spectrum_bar_peak_hold_top.f @@
rtl/sbph_pkg.sv
rtl/sbph_ram.sv
rtl/spectrum_bar_peak_hold_top.sv
sim/testbench.sv
